// File: src/grpa_pkg.sv
`default_nettype none

package grpa_pkg;

  localparam int ROW_W = 24;
  localparam int NNZ_W = 10;
  localparam int COST_W = 12;
  localparam int LOAD_W = 24;
  localparam int WORDS_W = 26;
  localparam int PE_OUT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int BASE_W = 9;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  localparam logic [WORDS_W-1:0] WORDS_MAX = {WORDS_W{1'b1}};
  localparam logic [BASE_W-1:0] JOB_BASE_RESET = 9'd11;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_WORDS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNLIMITED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_NONZEROS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PES = 3'd4;

  typedef struct packed {
    logic              new_job;
    logic              new_color;
    logic [ROW_W-1:0]  row_id;
    logic [NNZ_W-1:0]  row_nnz;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]    placed_row;
    logic [PE_OUT_W-1:0] assigned_pe;
    logic                failed;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic commit;
  } grpa_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic out_free;
  } grpa_sts_t;

endpackage

`default_nettype wire

// File: src/grpa_ram.sv
`default_nettype none

module grpa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/grpa_ctrl.sv
`default_nettype none

module grpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire grpa_pkg::grpa_sts_t sts,
  output grpa_pkg::grpa_cmd_t      cmd
);

  import grpa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/grpa_dp.sv
`default_nettype none

module grpa_dp #(
  parameter int NUM_PE = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire grpa_pkg::grpa_cmd_t                 cmd,
  output grpa_pkg::grpa_sts_t                      sts,
  input  wire grpa_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output grpa_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_we,
  input  wire logic [grpa_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [grpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import grpa_pkg::*;

  localparam int IW = (NUM_PE > 1) ? $clog2(NUM_PE) : 1;
  localparam int PW = IW + PE_OUT_W;

  // configuration
  logic [23:0]       cap_r;
  logic              unlim_r;
  logic [7:0]        colors_r;
  logic [LOAD_W-1:0] total_r;
  logic [3:0]        active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= 24'hFFFFFF;
      unlim_r  <= 1'b1;
      colors_r <= 8'd8;
      total_r  <= 24'hFFFFFF;
      active_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CAPACITY_WORDS: cap_r    <= cfg_wdata;
        REG_UNLIMITED:      unlim_r  <= cfg_wdata[0];
        REG_NUM_COLORS:     colors_r <= cfg_wdata[7:0];
        REG_TOTAL_NONZEROS: total_r  <= cfg_wdata;
        REG_ACTIVE_PES:     active_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // last scanned element index
  logic [IW-1:0] last_idx;
  always_comb begin
    int act;
    act = int'(active_r);
    if (act == 0) begin
      act = 1;
    end
    if (act > NUM_PE) begin
      act = NUM_PE;
    end
    last_idx = IW'(act - 1);
  end

  // item registers
  logic [ROW_W-1:0]  row_r;
  logic [NNZ_W-1:0]  nnz_r;
  logic [COST_W-1:0] cost_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_r  <= in_item.row_id;
      nnz_r  <= in_item.row_nnz;
      cost_r <= {1'b0, in_item.row_nnz, 1'b0} + COST_W'(3);
    end
  end

  // per-element stores with valid bits
  logic [NUM_PE-1:0] load_vld_r;
  logic [NUM_PE-1:0] words_vld_r;
  logic [BASE_W-1:0] job_base_r;
  logic [IW-1:0]     cnt_r;
  logic              eval_valid_r;
  logic [IW-1:0]     eval_idx_r;
  logic [LOAD_W-1:0]  load_q;
  logic [WORDS_W-1:0] words_q;

  logic [LOAD_W-1:0]  min_load_r;
  logic [IW-1:0]      pick_r;
  logic [LOAD_W-1:0]  pick_load_r;
  logic [WORDS_W-1:0] pick_words_r;
  logic               found_r;
  logic               fail_r;

  logic [LOAD_W-1:0]  new_load;
  logic [WORDS_W-1:0] new_words;
  logic               wr_en;

  always_comb begin
    logic [LOAD_W:0]  lsum;
    logic [WORDS_W:0] wsum;
    lsum = {1'b0, pick_load_r} + (LOAD_W+1)'(nnz_r);
    wsum = {1'b0, pick_words_r} + (WORDS_W+1)'(cost_r);
    new_load = lsum[LOAD_W] ? LOAD_MAX : lsum[LOAD_W-1:0];
    new_words = wsum[WORDS_W] ? WORDS_MAX : wsum[WORDS_W-1:0];
  end

  assign wr_en = cmd.commit && found_r;

  grpa_ram #(.WIDTH(LOAD_W), .DEPTH(NUM_PE)) u_load_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pick_r),
    .wdata (new_load),
    .raddr (cnt_r),
    .rdata (load_q)
  );

  grpa_ram #(.WIDTH(WORDS_W), .DEPTH(NUM_PE)) u_words_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pick_r),
    .wdata (new_words),
    .raddr (cnt_r),
    .rdata (words_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_vld_r  <= '0;
      words_vld_r <= '0;
      job_base_r  <= JOB_BASE_RESET;
      fail_r      <= 1'b0;
    end else begin
      if (cmd.accept && in_item.new_color) begin
        load_vld_r <= '0;
      end else if (wr_en) begin
        load_vld_r[pick_r] <= 1'b1;
      end
      if (cmd.accept && in_item.new_job) begin
        words_vld_r <= '0;
        job_base_r  <= BASE_W'(colors_r) + BASE_W'(3);
        fail_r      <= 1'b0;
      end else if (wr_en) begin
        words_vld_r[pick_r] <= 1'b1;
      end else if (cmd.commit) begin
        fail_r <= 1'b1;
      end
    end
  end

  // scan
  logic [LOAD_W-1:0]  cur_load;
  logic [WORDS_W-1:0] cur_words;
  logic               qual;
  logic               first;
  logic               better;

  always_comb begin
    logic [WORDS_W:0] need;
    cur_load  = load_vld_r[eval_idx_r] ? load_q : '0;
    cur_words = words_vld_r[eval_idx_r] ? words_q : WORDS_W'(job_base_r);
    need  = {1'b0, cur_words} + (WORDS_W+1)'(cost_r);
    qual  = unlim_r || (need <= (WORDS_W+1)'(cap_r));
    first = (eval_idx_r == '0);
    better = qual && ((cur_load < min_load_r) ||
             ((cur_load == min_load_r) && !first && (cur_words < pick_words_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_valid_r <= 1'b0;
    end else begin
      eval_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_r      <= '0;
      min_load_r <= total_r;
      pick_r     <= '0;
      found_r    <= 1'b0;
    end else begin
      if (cmd.issue) begin
        cnt_r      <= cnt_r + IW'(1);
        eval_idx_r <= cnt_r;
      end
      if (eval_valid_r) begin
        if (first || better) begin
          pick_load_r  <= cur_load;
          pick_words_r <= cur_words;
        end
        if (qual) begin
          found_r <= 1'b1;
        end
        if (better) begin
          min_load_r <= cur_load;
          pick_r     <= eval_idx_r;
        end
      end
    end
  end

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;
  logic [PW-1:0] pick_wide;

  assign pick_wide = found_r ? PW'(pick_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item_r.placed_row  <= row_r;
      out_item_r.assigned_pe <= pick_wide[PE_OUT_W-1:0];
      out_item_r.failed      <= fail_r || !found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign sts.issue_last = (cnt_r == last_idx);
  assign sts.out_free   = !out_valid_r || !out_stall;

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    eval_valid_r |-> (eval_idx_r <= last_idx))
    else $error("scan beyond active elements");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (pick_r <= last_idx))
    else $error("update of inactive element");

  a_job_clears_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_item.new_job) |=> !fail_r)
    else $error("fail flag not cleared by new job");

endmodule

`default_nettype wire

// File: src/greedy_row_to_pe_assigner_core.sv
`default_nettype none

// channel   direction  handshake                 payload
// in_       input      in_valid / in_stall       grpa_pkg::in_item_t
// out_      output     out_valid / out_stall     grpa_pkg::out_item_t
// cfg_      input      cfg_we                    cfg_idx, cfg_wdata
//
// each row is processed by the one-element-per-cycle scan over the first
// active_pes elements of the load and word memories
// the next row is taken while the previous result waits in the output register
// a stalled output holds the scan result until the output register frees up
// rst_n is synchronous; counters restart empty, word counts at three plus eight

module greedy_row_to_pe_assigner_core #(
  parameter int NUM_PE = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire grpa_pkg::in_item_t               in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output grpa_pkg::out_item_t                   out_item,
  input  wire logic                             cfg_we,
  input  wire logic [grpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [grpa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import grpa_pkg::*;

  grpa_cmd_t cmd;
  grpa_sts_t sts;

  grpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  grpa_dp #(.NUM_PE(NUM_PE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire
